// ----- rtl/base64_stream_encoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared assertion forms for the encoder checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define B64SE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define B64SE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/b64se_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Beat types, the command carried from front to back, and the alphabet.
// ----------------------------------------------------------------------------
`default_nettype none

package b64se_pkg;

    // Default depth of the command queue
    localparam int unsigned B64SE_QUEUE_DEPTH = 2;

    localparam logic [7:0] B64SE_PAD_CHAR = 8'h3D;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_b64se_in;

    // Output beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_b64se_out;

    // Characters produced by one input byte, emitted by the back end
    typedef struct packed {
        logic [3:0][7:0] chars;     // chars[0] goes out first
        logic [1:0]      last_idx;  // number of chars minus one
        logic            fin;       // last char closes the message
    } t_b64se_cmd;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_b64se_qstat;

    // Map a sextet to its base64 ASCII code
    function automatic logic [7:0] b64se_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'h41;           // 'A'..'Z'
        end else if (v < 6'd52) begin
            return w + 8'd71;           // 'a'..'z'
        end else if (v < 6'd62) begin
            return w - 8'd4;            // '0'..'9'
        end else if (v == 6'd62) begin
            return 8'h2B;               // '+'
        end else begin
            return 8'h2F;               // '/'
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/base64_stream_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into base64 ASCII (A-Z a-z 0-9 + /) with '='
// padding on the final byte and a flag on the last character.
//
//   Channel   Direction  Handshake                  Beat
//   in        input      i_in_valid / o_in_stall    t_b64se_in  (byte, final)
//   out       output     o_out_valid / i_out_stall  t_b64se_out (char, last)
//
// One output character per cycle while commands wait and i_out_stall is
// low, set by the back end's output register; a byte makes one to four
// characters, about 4/3 on average (two to four on a final byte).
// Bytes enter at one per cycle while the command queue has room.
// Reset is synchronous; it empties the queue and returns to group start.
// Output stall holds the output beat; the queue lets the front keep taking
// bytes until it fills, then o_in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_unit
    import b64se_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B64SE_QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  t_b64se_in  i_in_beat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_b64se_out o_out_beat,
    input  wire        i_out_stall
);

    t_b64se_qstat qstat;
    t_b64se_cmd   push_cmd, head_cmd;
    logic         push, pop;

    // Byte classification
    b64se_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Command queue
    b64se_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_qstat (qstat)
    );

    // Character emission
    b64se_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- rtl/b64se_front.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks group position and leftover bits, and turns each
// byte into a command of one to four characters for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_front
    import b64se_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  t_b64se_in    i_in_beat,
    output logic         o_in_stall,
    input  t_b64se_qstat i_qstat,
    output logic         o_push,
    output t_b64se_cmd   o_cmd
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic [7:0] b;
    logic       fin;

    assign b          = i_in_beat.data_byte;
    assign fin        = i_in_beat.final_byte;
    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    // Classify the byte by group position and build its characters
    always_comb begin
        o_cmd       = '0;
        o_cmd.fin   = fin;
        n_phase     = r_phase;
        n_left      = r_left;
        unique case (r_phase)
            PH_SECOND: begin
                o_cmd.chars[0] = b64se_char({r_left[1:0], b[7:4]});
                o_cmd.chars[1] = b64se_char({b[3:0], 2'b00});
                o_cmd.chars[2] = B64SE_PAD_CHAR;
                o_cmd.last_idx = fin ? 2'd2 : 2'd0;
                n_left         = b[3:0];
                n_phase        = PH_THIRD;
            end
            PH_THIRD: begin
                o_cmd.chars[0] = b64se_char({r_left, b[7:6]});
                o_cmd.chars[1] = b64se_char(b[5:0]);
                o_cmd.last_idx = 2'd1;
                n_left         = 4'd0;
                n_phase        = PH_FIRST;
            end
            default: begin
                // start of group, also the unused phase code
                o_cmd.chars[0] = b64se_char(b[7:2]);
                o_cmd.chars[1] = b64se_char({b[1:0], 4'b0000});
                o_cmd.chars[2] = B64SE_PAD_CHAR;
                o_cmd.chars[3] = B64SE_PAD_CHAR;
                o_cmd.last_idx = fin ? 2'd3 : 2'd0;
                n_left         = {2'b00, b[1:0]};
                n_phase        = PH_SECOND;
            end
        endcase
        if (fin) begin
            n_phase = PH_FIRST;
            n_left  = 4'd0;
        end
    end

    // Group state advances on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64se_queue.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder command queue
// Short FIFO of character commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_queue
    import b64se_pkg::*;
#(
    parameter int unsigned DEPTH = B64SE_QUEUE_DEPTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  t_b64se_cmd   i_cmd,
    input  wire          i_pop,
    output t_b64se_cmd   o_head,
    output t_b64se_qstat o_qstat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_b64se_cmd    r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == FULL_CNT);
    assign o_qstat.empty = (r_cnt == '0);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64se_back.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks commands into the output register, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_back
    import b64se_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_b64se_qstat i_qstat,
    input  t_b64se_cmd   i_head,
    output logic         o_pop,
    output logic         o_out_valid,
    output t_b64se_out   o_out_beat,
    input  wire          i_out_stall
);

    logic       r_busy;
    t_b64se_cmd r_cur;
    logic [1:0] r_idx;
    logic       r_ovalid;
    t_b64se_out r_obeat;

    logic out_free, take, at_last, cur_done;

    assign out_free = !r_ovalid || !i_out_stall;
    assign take     = out_free && r_busy;
    assign at_last  = (r_idx == r_cur.last_idx);
    assign cur_done = take && at_last;
    assign o_pop    = !i_qstat.empty && (!r_busy || cur_done);

    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

    // Command tracking and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (cur_done) begin
                r_busy <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
            end
            if (out_free) begin
                r_ovalid <= take;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (take) begin
            r_obeat.out_char  <= r_cur.chars[r_idx];
            r_obeat.last_char <= r_cur.fin && at_last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64se_checker.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_encoder_unit_macros.svh"

module b64se_checker
    import b64se_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input t_b64se_out o_out_beat,
    input wire        i_out_stall
);

    logic [7:0] ch;
    logic       legal;
    logic       pad_mid;

    assign ch    = o_out_beat.out_char;
    assign legal = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)
                || (ch >= 8'h30 && ch <= 8'h39) || ch == 8'h2B || ch == 8'h2F
                || ch == B64SE_PAD_CHAR;
    // a padding beat taken that does not end the message
    assign pad_mid = o_out_valid && !i_out_stall && ch == B64SE_PAD_CHAR
                  && !o_out_beat.last_char;

    // Stalled output beat holds
    `B64SE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_beat), "output beat changed under stall")

    // Only alphabet or padding characters appear
    `B64SE_ASSERT_NOW(a_out_legal, i_clk, i_rst_n, o_out_valid, legal, "illegal base64 character")

    // Padding runs without a gap to the end of the message
    `B64SE_ASSERT_NEXT(a_pad_run, i_clk, i_rst_n, pad_mid, o_out_valid && o_out_beat.out_char == B64SE_PAD_CHAR, "padding not followed by padding")

endmodule

bind base64_stream_encoder_unit b64se_checker u_b64se_checker (.*);

`default_nettype wire

// ----- tb/base64_stream_encoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Sends byte messages into the encoder and predicts every base64 character
// it should produce, including the flush, the '=' padding and the
// last-character flag. Directed messages cover each group position with and
// without a final byte. Random messages follow, sent under random idling
// on both channels, with one long output hold-off and one stretch without
// any gaps.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit_tb;
    import b64se_pkg::*;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int RX_HOLD_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Position of the next byte within its three-byte group
    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2
    } t_grp_pos;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_b64se_in  i_in_beat   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_b64se_out o_out_beat;

    // Encoder state as predicted
    t_grp_pos   grp_pos    = GRP_FIRST;
    logic [3:0] carry_bits = '0;
    t_b64se_out expected_chars[$];

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  msgs_sent     = 0;
    int  chars_checked = 0;
    int  idle_cycles   = 0;
    int  holds_done    = 0;
    bit  no_idle       = 1'b0;
    bit  rx_hold_req   = 1'b0;
    bit  rx_hold_on    = 1'b0;

    base64_stream_encoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
        return B64_ALPHABET[v];
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        t_b64se_out b;
        b.out_char  = c;
        b.last_char = last;
        expected_chars.push_back(b);
    endtask

    // Queue the characters one accepted byte completes
    task automatic encode_byte(input logic [7:0] d, input logic fin);
        case (grp_pos)
            GRP_SECOND: begin
                push_char(sextet_ascii({carry_bits[1:0], d[7:4]}), 1'b0);
                carry_bits = d[3:0];
                grp_pos    = GRP_THIRD;
                if (fin) begin
                    push_char(sextet_ascii({carry_bits, 2'b00}), 1'b0);
                    push_char(B64SE_PAD_CHAR, 1'b1);
                end
            end
            GRP_THIRD: begin
                push_char(sextet_ascii({carry_bits, d[7:6]}), 1'b0);
                push_char(sextet_ascii(d[5:0]), fin);
                carry_bits = '0;
                grp_pos    = GRP_FIRST;
            end
            default: begin
                // start of group; any stale carry is ignored
                push_char(sextet_ascii(d[7:2]), 1'b0);
                carry_bits = {2'b00, d[1:0]};
                grp_pos    = GRP_SECOND;
                if (fin) begin
                    push_char(sextet_ascii({d[1:0], 4'b0000}), 1'b0);
                    push_char(B64SE_PAD_CHAR, 1'b0);
                    push_char(B64SE_PAD_CHAR, 1'b1);
                end
            end
        endcase
        if (fin) begin
            grp_pos    = GRP_FIRST;
            carry_bits = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Idling: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one beat and wait until it is taken
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic fin);
        int        gap;
        t_b64se_in beat;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat.data_byte  = d;
        beat.final_byte = fin;
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        encode_byte(d, fin);
        bytes_sent++;
        if (fin) msgs_sent++;
    endtask

    task automatic send_random_message(input int len);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            // lean on the extremes now and then
            case ($urandom_range(0, 9))
                0:       d = 8'h00;
                1:       d = 8'hFF;
                default: d = 8'($urandom_range(0, 255));
            endcase
            send_byte(d, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall runs, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int run;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_hold_on  = 1'b1;
                i_out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_on  = 1'b0;
                holds_done++;
            end else begin
                run = pick_gap();
                i_out_stall <= (run != 0);
                repeat ((run == 0) ? $urandom_range(1, 12) : run) @(posedge i_clk);
            end
        end
    end

    // Compare each taken output beat with the oldest predicted character
    always @(posedge i_clk) begin : char_check
        t_b64se_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected char beat: got char %h last %b",
                         $realtime, o_out_beat.out_char, o_out_beat.last_char);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (o_out_beat.out_char !== want.out_char) begin
                    mismatches++;
                    $display("%0t: out_char mismatch: expected %h actual %h",
                             $realtime, want.out_char, o_out_beat.out_char);
                end
                if (o_out_beat.last_char !== want.last_char) begin
                    mismatches++;
                    $display("%0t: last_char mismatch: expected %b actual %b",
                             $realtime, want.last_char, o_out_beat.last_char);
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $realtime, idle_cycles);
                $display("base64_stream_encoder_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Known messages: final at each group position, extremes, '+' and '/'
    task automatic test_directed();
        send_byte(8'h4D, 1'b1);                                   // TQ==
        send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b1);           // TWE=
        send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);                                   // TWFu
        send_byte(8'h00, 1'b1);                                   // AA==
        send_byte(8'hFF, 1'b1);                                   // /w==
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);           // //8=
        send_byte(8'hFB, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);                                   // +/+/
        // several groups, final on the first byte of the third
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Random messages, mostly short, some long
    task automatic test_random_messages(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6)
                                             : $urandom_range(7, 40);
            send_random_message(len);
            sent += len;
        end
    endtask

    // Output held off while bytes keep coming, so the input stalls
    task automatic test_back_pressure();
        i_in_valid  <= 1'b0;
        rx_hold_req = 1'b1;
        while (!rx_hold_on) @(posedge i_clk);
        no_idle = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i % 5 == 4) || (i == 23));
        end
        no_idle = 1'b0;
    endtask

    // No gaps on either side
    task automatic test_back_to_back(input int n_items);
        no_idle = 1'b1;
        test_random_messages(n_items);
        no_idle = 1'b0;
    endtask

    initial begin : run
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_messages(130);
        test_back_pressure();
        test_back_to_back(60);
        test_random_messages(135);

        // drain
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            mismatches += expected_chars.size();
            $display("%0t: %0d predicted chars never arrived",
                     $realtime, expected_chars.size());
        end

        $display("Encoded %0d bytes in %0d messages; %0d chars checked.",
                 bytes_sent, msgs_sent, chars_checked);
        $display("Output held off %0d cycles %0d time(s) under a full input; %0d mismatches.",
                 RX_HOLD_CYCLES, holds_done, mismatches);
        if (mismatches == 0) begin
            $display("base64_stream_encoder_unit_tb OK");
        end else begin
            $display("base64_stream_encoder_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
